### src/stc_pkg.sv
// Shared types, scancode constants and character ROM functions for the
// scancode-to-character translator. No dependencies.
package stc_pkg;

  // Scancodes with special handling.
  localparam logic [7:0] SC_PFX_E0    = 8'he0;
  localparam logic [7:0] SC_PFX_E1    = 8'he1;
  localparam logic [7:0] SC_CTRL      = 8'h1d;
  localparam logic [7:0] SC_LSHIFT    = 8'h2a;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_MINUS     = 8'h35;
  localparam logic [7:0] SC_CAPS      = 8'h3a;
  localparam logic [7:0] SC_NUM       = 8'h45;
  localparam logic [7:0] SC_SCROLL    = 8'h46;
  localparam logic [7:0] SC_CTRL_BRK  = 8'h9d;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hb6;
  localparam logic [7:0] SC_ALT_BRK   = 8'hb8;
  localparam logic [7:0] SC_CAPS_BRK  = 8'hba;

  // Modifier mode bit positions.
  localparam int MB_LSHIFT = 0;
  localparam int MB_RSHIFT = 1;
  localparam int MB_LCTRL  = 2;
  localparam int MB_RCTRL  = 3;
  localparam int MB_ALT    = 4;
  localparam int MB_ALTGR  = 5;
  localparam int MB_CAPS   = 6;
  localparam int MB_HELD   = 7;

  // LED bit positions.
  localparam int LB_SCROLL = 0;
  localparam int LB_NUM    = 1;
  localparam int LB_CAPS   = 2;

  localparam logic [7:0] CH_SLASH = 8'h2f;

  // Prefix state codes.
  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_E0   = 2'd1,
    PFX_E1   = 2'd2
  } pfx_t;

  // What the back end has to do with a transaction.
  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_XLATE = 2'd1,
    K_SLASH = 2'd2
  } kind_t;

  // One classified transaction handed from front end to back end.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] idx;       // ROM index, always below 0x61 for translated keys
    logic [6:0] mods;      // modifier bits 0..6 as they stood before this code
    logic       led_write;
    logic [2:0] led_bits;
  } fe_item_t;

  // True for the make codes that go through the character tables.
  function automatic logic is_char_key(input logic [7:0] code);
    logic r;
    r = 1'b0;
    if (code >= 8'h01 && code <= 8'h1c) r = 1'b1;
    if (code >= 8'h1e && code <= 8'h29) r = 1'b1;
    if (code >= 8'h2b && code <= 8'h34) r = 1'b1;
    if (code == 8'h37 || code == 8'h39) r = 1'b1;
    if (code == 8'h4a || code == 8'h4e || code == 8'h56) r = 1'b1;
    return r;
  endfunction

  // Unshifted layout.
  function automatic logic [7:0] base_rom(input logic [6:0] a);
    logic [7:0] c;
    case (a)
      7'h01: c = 8'h1b; 7'h02: c = 8'h31; 7'h03: c = 8'h32; 7'h04: c = 8'h33;
      7'h05: c = 8'h34; 7'h06: c = 8'h35; 7'h07: c = 8'h36; 7'h08: c = 8'h37;
      7'h09: c = 8'h38; 7'h0a: c = 8'h39; 7'h0b: c = 8'h30; 7'h0c: c = 8'h2b;
      7'h0e: c = 8'h7f; 7'h0f: c = 8'h09;
      7'h10: c = 8'h71; 7'h11: c = 8'h77; 7'h12: c = 8'h65; 7'h13: c = 8'h72;
      7'h14: c = 8'h74; 7'h15: c = 8'h79; 7'h16: c = 8'h75; 7'h17: c = 8'h69;
      7'h18: c = 8'h6f; 7'h19: c = 8'h70; 7'h1a: c = 8'he5; 7'h1c: c = 8'h0a;
      7'h1e: c = 8'h61; 7'h1f: c = 8'h73;
      7'h20: c = 8'h64; 7'h21: c = 8'h66; 7'h22: c = 8'h67; 7'h23: c = 8'h68;
      7'h24: c = 8'h6a; 7'h25: c = 8'h6b; 7'h26: c = 8'h6c; 7'h27: c = 8'hf6;
      7'h28: c = 8'he4; 7'h2c: c = 8'h7a; 7'h2d: c = 8'h78; 7'h2e: c = 8'h63;
      7'h2f: c = 8'h76;
      7'h30: c = 8'h62; 7'h31: c = 8'h6e; 7'h32: c = 8'h6d; 7'h33: c = 8'h2c;
      7'h34: c = 8'h2e; 7'h35: c = 8'h2d; 7'h37: c = 8'h2a; 7'h39: c = 8'h20;
      7'h4a: c = 8'h2d; 7'h4e: c = 8'h2b; 7'h56: c = 8'h3c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted layout.
  function automatic logic [7:0] shift_rom(input logic [6:0] a);
    logic [7:0] c;
    case (a)
      7'h01: c = 8'h1b; 7'h02: c = 8'h21; 7'h03: c = 8'h22; 7'h04: c = 8'h23;
      7'h06: c = 8'h25; 7'h07: c = 8'h26; 7'h08: c = 8'h2f; 7'h09: c = 8'h28;
      7'h0a: c = 8'h29; 7'h0b: c = 8'h3d; 7'h0c: c = 8'h3f; 7'h0d: c = 8'h60;
      7'h0e: c = 8'h7f; 7'h0f: c = 8'h09;
      7'h10: c = 8'h51; 7'h11: c = 8'h57; 7'h12: c = 8'h45; 7'h13: c = 8'h52;
      7'h14: c = 8'h54; 7'h15: c = 8'h59; 7'h16: c = 8'h55; 7'h17: c = 8'h49;
      7'h18: c = 8'h4f; 7'h19: c = 8'h50; 7'h1a: c = 8'hc5; 7'h1b: c = 8'h5e;
      7'h1c: c = 8'h0a; 7'h1e: c = 8'h41; 7'h1f: c = 8'h53;
      7'h20: c = 8'h44; 7'h21: c = 8'h46; 7'h22: c = 8'h47; 7'h23: c = 8'h48;
      7'h24: c = 8'h4a; 7'h25: c = 8'h4b; 7'h26: c = 8'h4c; 7'h27: c = 8'hd6;
      7'h28: c = 8'hc4; 7'h2b: c = 8'h2a; 7'h2c: c = 8'h5a; 7'h2d: c = 8'h58;
      7'h2e: c = 8'h43; 7'h2f: c = 8'h56;
      7'h30: c = 8'h42; 7'h31: c = 8'h4e; 7'h32: c = 8'h4d; 7'h33: c = 8'h3b;
      7'h34: c = 8'h3a; 7'h35: c = 8'h5f; 7'h37: c = 8'h2a; 7'h39: c = 8'h20;
      7'h4a: c = 8'h2d; 7'h4e: c = 8'h2b; 7'h56: c = 8'h3e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Alt-gr layout.
  function automatic logic [7:0] altgr_rom(input logic [6:0] a);
    logic [7:0] c;
    case (a)
      7'h03: c = 8'h40; 7'h05: c = 8'h24; 7'h08: c = 8'h7c; 7'h09: c = 8'h5b;
      7'h0a: c = 8'h5d; 7'h1b: c = 8'h7e; 7'h1c: c = 8'h0a; 7'h56: c = 8'h7c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/stc_front.sv
// Front end of the translator: holds modifier, LED and prefix state and
// classifies each accepted scancode into a queue item. Depends on stc_pkg.
module stc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       scancode,
  output stc_pkg::fe_item_t item,
  output stc_pkg::pfx_t    prefix
);
  import stc_pkg::*;

  logic [7:0] mode_r, mode_nxt;
  logic [2:0] led_r, led_nxt;
  pfx_t       pfx_r, pfx_nxt;
  logic       pre;
  logic       ledw;
  kind_t      kind;

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      led_r  <= '0;
      pfx_r  <= PFX_NONE;
    end else if (accept) begin
      mode_r <= mode_nxt;
      led_r  <= led_nxt;
      pfx_r  <= pfx_nxt;
    end
  end

  // Decode of the scancode against the current state.
  always_comb begin
    pre      = (pfx_r != PFX_NONE);
    mode_nxt = mode_r;
    led_nxt  = led_r;
    pfx_nxt  = PFX_NONE;
    ledw     = 1'b0;
    kind     = K_NONE;
    case (scancode)
      SC_PFX_E0: pfx_nxt = PFX_E0;
      SC_PFX_E1: pfx_nxt = PFX_E1;
      SC_CTRL: begin
        if (pfx_r == PFX_NONE) mode_nxt[MB_LCTRL] = 1'b1;
        else if (pfx_r == PFX_E0) mode_nxt[MB_RCTRL] = 1'b1;
      end
      SC_LSHIFT: mode_nxt[MB_LSHIFT] = 1'b1;
      SC_RSHIFT: mode_nxt[MB_RSHIFT] = 1'b1;
      SC_ALT: begin
        if (pre) mode_nxt[MB_ALTGR] = 1'b1;
        else mode_nxt[MB_ALT] = 1'b1;
      end
      SC_MINUS: kind = pre ? K_SLASH : K_XLATE;
      SC_CAPS: begin
        // Auto-repeat of a held caps key does not toggle again.
        if (!mode_r[MB_HELD]) begin
          led_nxt[LB_CAPS]  = ~led_r[LB_CAPS];
          mode_nxt[MB_CAPS] = ~mode_r[MB_CAPS];
          mode_nxt[MB_HELD] = 1'b1;
        end
        ledw = 1'b1;
      end
      SC_NUM: begin
        led_nxt[LB_NUM] = ~led_r[LB_NUM];
        ledw = 1'b1;
      end
      SC_SCROLL: begin
        led_nxt[LB_SCROLL] = ~led_r[LB_SCROLL];
        ledw = 1'b1;
      end
      SC_CTRL_BRK: begin
        if (pre) mode_nxt[MB_RCTRL] = 1'b0;
        else mode_nxt[MB_LCTRL] = 1'b0;
      end
      SC_LSHIFT_BRK: mode_nxt[MB_LSHIFT] = 1'b0;
      SC_RSHIFT_BRK: mode_nxt[MB_RSHIFT] = 1'b0;
      SC_ALT_BRK: begin
        if (pre) mode_nxt[MB_ALTGR] = 1'b0;
        else mode_nxt[MB_ALT] = 1'b0;
      end
      SC_CAPS_BRK: begin
        mode_nxt[MB_HELD] = 1'b0;
        ledw = 1'b1;
      end
      default: begin
        if (is_char_key(scancode)) kind = K_XLATE;
      end
    endcase
  end

  // Item for the back end; the translation uses the mode before this code.
  always_comb begin
    item.kind      = kind;
    item.idx       = scancode[6:0];
    item.mods      = mode_r[6:0];
    item.led_write = ledw;
    item.led_bits  = led_nxt;
  end

  assign prefix = pfx_r;

endmodule

### src/stc_queue.sv
// Short queue of classified items between front end and back end.
// Depends on stc_pkg for the item type.
module stc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  stc_pkg::fe_item_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output stc_pkg::fe_item_t rd_data,
  output logic              rd_valid
);
  import stc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fe_item_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) store_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = store_r[rd_ptr_r];

endmodule

### src/stc_back.sv
// Back end of the translator: ROM lookup and modifier post-processing,
// then the registered result stage. Depends on stc_pkg.
module stc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  stc_pkg::fe_item_t item,
  input  logic              item_valid,
  output logic              item_take,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        char_code,
  output logic              char_valid,
  output logic              led_write,
  output logic [2:0]        led_bits
);
  import stc_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] code_r;
  logic       cval_r;
  logic       ledw_r;
  logic [2:0] leds_r;
  logic [7:0] rom_c, c1, c2, ch;
  logic       out_take, load;

  // Table lookup and modifier rules for a translated key.
  always_comb begin
    if (item.mods[MB_ALTGR]) rom_c = altgr_rom(item.idx);
    else if (item.mods[MB_LSHIFT] || item.mods[MB_RSHIFT]) rom_c = shift_rom(item.idx);
    else rom_c = base_rom(item.idx);
    c1 = rom_c;
    if (item.mods[MB_CAPS] && rom_c >= 8'h61 && rom_c <= 8'h7a) c1 = rom_c - 8'h20;
    c2 = c1;
    if ((item.mods[MB_LCTRL] || item.mods[MB_RCTRL]) && c1 >= 8'h40 && c1 < 8'h60) begin
      c2 = c1 - 8'h40;
    end
    case (item.kind)
      K_XLATE: ch = item.mods[MB_ALT] ? (c2 | 8'h80) : c2;
      K_SLASH: ch = CH_SLASH;
      default: ch = 8'h00;
    endcase
  end

  // Result stage: refills while the current result is being taken.
  assign out_take      = pop && out_valid_r;
  assign load          = item_valid && (!out_valid_r || out_take);
  assign item_take     = load;
  assign out_valid_nxt = load || (out_valid_r && !out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= ch;
      cval_r <= (ch != 8'h00);
      ledw_r <= item.led_write;
      leds_r <= item.led_bits;
    end
  end

  assign empty      = !out_valid_r;
  assign char_code  = code_r;
  assign char_valid = cval_r;
  assign led_write  = ledw_r;
  assign led_bits   = leds_r;

endmodule

### src/scancode_to_char_translator.sv
// Set-1 keyboard scancode to character translator, top level.
// Instantiates stc_front, stc_queue and stc_back; depends on stc_pkg.
//
// Every scancode pushed in gives exactly one result, in order, including
// prefix and release codes, which give a zero character. A new scancode is
// accepted every cycle while the internal queue of DEPTH entries has room;
// a scancode is written into the queue after the front end, then goes
// through the ROM lookup into the output register when that register is
// empty or being taken by pop. Modifier, caps lock, LED and E0/E1 prefix
// state live in the front end and update in the cycle of acceptance.
// led_write asks the host to send 0xED followed by led_bits to the
// keyboard. Function and cursor keys produce no character.
module scancode_to_char_translator #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_scancode,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_code,
  output logic       out_char_valid,
  output logic       out_led_write,
  output logic [2:0] out_led_bits
);
  import stc_pkg::*;

  fe_item_t fe_item, q_item;
  pfx_t     prefix;
  logic     in_fire, q_valid, q_take;

  assign in_fire = push && !full;

  // Front end: state tracking and classification.
  stc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_fire),
    .scancode (in_scancode),
    .item     (fe_item),
    .prefix   (prefix)
  );

  // Decoupling queue.
  stc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (fe_item),
    .full     (full),
    .rd_en    (q_take),
    .rd_data  (q_item),
    .rd_valid (q_valid)
  );

  // Back end: translation and result register.
  stc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_valid (q_valid),
    .item_take  (q_take),
    .pop        (pop),
    .empty      (empty),
    .char_code  (out_char_code),
    .char_valid (out_char_valid),
    .led_write  (out_led_write),
    .led_bits   (out_led_bits)
  );

  // LED requests come only from lock keys, which never produce a character.
  a_ledw_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_led_write && out_char_valid))
    else $error("result carries both an LED request and a character");

  // An E0 prefix byte leaves the front end waiting for the second byte.
  a_prefix_e0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_scancode == SC_PFX_E0) |=> (prefix == PFX_E0))
    else $error("E0 prefix not recorded");

  // A taken result with nothing queued behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !q_valid) |=> empty)
    else $error("result repeated after it was taken");

endmodule
